FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define CLQM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen at a rising edge outside reset
`define CLQM_NEVER(lbl, clk, rstn, cond, msg) \
  `CLQM_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

FILE: rtl/clqm_pkg.sv
// types and constants for the circular linked queue manager
// no dependencies; used by the top level and its checker
package clqm_pkg;

  localparam int POOL_SIZE = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef struct packed {
    func_e             func;
    logic [IDX_W-1:0]  elem_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  elem_echo;
    logic [CNT_W-1:0]  size;
    logic [IDX_W-1:0]  head_index;
  } res_t;

endpackage

FILE: rtl/circular_linked_queue_manager.sv
// an item accepted at one edge is worked in the next cycle and its
// result sits on res_o for the cycle after that, shown for one cycle with done_o high
// throughput: one item per cycle; busy_o stays low, each item updates at most
// two next links and two prev links in the flop arrays at the same clock edge
// reset: queue empty, head zero, no item in flight; link arrays are not cleared
// depends on clqm_pkg
module circular_linked_queue_manager (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  clqm_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output clqm_pkg::res_t res_o
);
  import clqm_pkg::*;

  logic                 in_valid_q;
  req_t                 req_q;
  logic [IDX_W-1:0]     next_q [POOL_SIZE];
  logic [IDX_W-1:0]     prev_q [POOL_SIZE];
  logic [POOL_SIZE-1:0] member_q, member_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     occ_q, occ_d;
  logic                 done_q;
  res_t                 res_q;

  logic [IDX_W-1:0] e, tail, nx, pv;
  logic             in_range;
  status_e          st;
  logic             n_we0, n_we1, p_we0, p_we1;
  logic [IDX_W-1:0] n_addr0, n_addr1, p_addr0, p_addr1;
  logic [IDX_W-1:0] n_data0, n_data1, p_data0, p_data1;

  // block never stalls the sender
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    e        = req_q.elem_index;
    in_range = CNT_W'(e) < CNT_W'(POOL_SIZE);
    tail     = prev_q[head_q];
    nx       = next_q[e];
    pv       = prev_q[e];
    st       = ST_OK;
    head_d   = head_q;
    occ_d    = occ_q;
    member_d = member_q;
    n_we0 = 1'b0; n_addr0 = e; n_data0 = e;
    n_we1 = 1'b0; n_addr1 = e; n_data1 = e;
    p_we0 = 1'b0; p_addr0 = e; p_data0 = e;
    p_we1 = 1'b0; p_addr1 = e; p_data1 = e;
    if (in_valid_q) begin
      unique case (req_q.func)
        FUNC_APPEND: begin
          priority if (!in_range) begin
            st = ST_ABSENT;
          end else if (member_q[e]) begin
            st = ST_DUP;
          end else if (occ_q == '0) begin
            // first element links to itself
            head_d      = e;
            n_we0       = 1'b1;
            p_we0       = 1'b1;
            member_d[e] = 1'b1;
            occ_d       = CNT_W'(1);
          end else begin
            // splice in between tail and head
            n_we0 = 1'b1; n_addr0 = e;      n_data0 = head_q;
            p_we0 = 1'b1; p_addr0 = e;      p_data0 = tail;
            n_we1 = 1'b1; n_addr1 = tail;   n_data1 = e;
            p_we1 = 1'b1; p_addr1 = head_q; p_data1 = e;
            member_d[e] = 1'b1;
            occ_d       = occ_q + CNT_W'(1);
          end
        end
        FUNC_REMOVE: begin
          priority if (occ_q == '0) begin
            st = ST_EMPTY;
          end else if (!in_range || !member_q[e]) begin
            st = ST_ABSENT;
          end else if (occ_q == CNT_W'(1)) begin
            member_d[e] = 1'b0;
            occ_d       = '0;
            head_d      = '0;
          end else begin
            n_we0 = 1'b1; n_addr0 = pv; n_data0 = nx;
            p_we0 = 1'b1; p_addr0 = nx; p_data0 = pv;
            if (head_q == e) begin
              head_d = nx;
            end
            member_d[e] = 1'b0;
            occ_d       = occ_q - CNT_W'(1);
          end
        end
        default: begin
          st = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_q <= '0;
      head_q   <= '0;
      occ_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      member_q <= member_d;
      head_q   <= head_d;
      occ_q    <= occ_d;
      done_q   <= in_valid_q;
    end
  end

  // link arrays: only read for queued elements, so no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (n_we1 && n_addr1 == IDX_W'(i)) begin
        next_q[i] <= n_data1;
      end else if (n_we0 && n_addr0 == IDX_W'(i)) begin
        next_q[i] <= n_data0;
      end
      if (p_we1 && p_addr1 == IDX_W'(i)) begin
        prev_q[i] <= p_data1;
      end else if (p_we0 && p_addr0 == IDX_W'(i)) begin
        prev_q[i] <= p_data0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q.status     <= st;
      res_q.elem_echo  <= e;
      res_q.size       <= occ_d;
      res_q.head_index <= (occ_d == '0) ? '0 : head_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/clqm_checker.sv
// port-level checks for the circular linked queue manager, bound to the top level
// depends on clqm_pkg and assert_macros.svh
`include "assert_macros.svh"

module clqm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           done_o,
  input clqm_pkg::res_t res_o
);
  import clqm_pkg::*;

  `CLQM_ASSERT(a_item_gives_result, clk_i, rst_ni, (start_i && !busy_o) |=> ##1 done_o, "accepted item gave no result")
  `CLQM_ASSERT(a_result_has_item, clk_i, rst_ni, done_o |-> $past(start_i && !busy_o, 2), "result without an accepted item")
  `CLQM_NEVER(a_empty_head, clk_i, rst_ni, done_o && res_o.size == '0 && res_o.head_index != '0, "empty queue reports nonzero head")
  `CLQM_NEVER(a_empty_status, clk_i, rst_ni, done_o && res_o.status == ST_EMPTY && res_o.size != '0, "empty status with nonzero size")
  `CLQM_NEVER(a_dup_status, clk_i, rst_ni, done_o && res_o.status == ST_DUP && res_o.size == '0, "already queued reported on an empty queue")

endmodule

bind circular_linked_queue_manager clqm_checker u_clqm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for circular_linked_queue_manager: directed table, then random append/remove
// bursts that sweep the queue between empty and full; results checked against the table or a shadow queue
// depends on clqm_pkg and the circular_linked_queue_manager rtl
module tb_top;
  import clqm_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RAND_ITEMS = 600;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } row_t;

  typedef struct {
    bit   typed;
    res_t res;
  } known_ans_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  res_t res_o;

  // shadow of the queue, advanced when an item is accepted
  logic [IDX_W-1:0] nxt_link [POOL_SIZE];
  logic [IDX_W-1:0] prv_link [POOL_SIZE];
  logic [POOL_SIZE-1:0] in_queue = '0;
  logic [IDX_W-1:0] head_slot = '0;
  logic [CNT_W-1:0] queue_len = '0;

  res_t       expected_q [$];
  known_ans_t known_ans_q [$];
  row_t       dir_rows [$];
  int         mismatch_cnt = 0;
  int         idle_cycles = 0;

  // driver-side membership, used to pick well-formed appends and removals
  logic [POOL_SIZE-1:0] drv_member = '0;
  int                   drv_len = 0;

  circular_linked_queue_manager dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic res_t apply_queue_op(req_t r);
    res_t             o;
    status_e          st;
    logic [IDX_W-1:0] e;
    logic [IDX_W-1:0] tl;
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] pv;
    e = r.elem_index;
    st = ST_OK;
    if (r.func == FUNC_APPEND) begin
      if (int'(e) >= POOL_SIZE) begin
        st = ST_ABSENT;
      end else if (in_queue[e]) begin
        st = ST_DUP;
      end else if (queue_len == 0) begin
        head_slot = e;
        nxt_link[e] = e;
        prv_link[e] = e;
        in_queue[e] = 1'b1;
        queue_len = CNT_W'(1);
      end else begin
        // new tail sits just before the head
        tl = prv_link[head_slot];
        nxt_link[e] = head_slot;
        prv_link[e] = tl;
        nxt_link[tl] = e;
        prv_link[head_slot] = e;
        in_queue[e] = 1'b1;
        queue_len = queue_len + CNT_W'(1);
      end
    end else begin
      if (queue_len == 0) begin
        st = ST_EMPTY;
      end else if (int'(e) >= POOL_SIZE || !in_queue[e]) begin
        st = ST_ABSENT;
      end else if (queue_len == 1) begin
        in_queue[e] = 1'b0;
        queue_len = '0;
        head_slot = '0;
      end else begin
        nx = nxt_link[e];
        pv = prv_link[e];
        nxt_link[pv] = nx;
        prv_link[nx] = pv;
        if (head_slot == e) head_slot = nx;
        in_queue[e] = 1'b0;
        queue_len = queue_len - CNT_W'(1);
      end
    end
    o.status = st;
    o.elem_echo = e;
    o.size = queue_len;
    o.head_index = (queue_len == 0) ? '0 : head_slot;
    return o;
  endfunction

  task automatic flag_field(input string fld, input int exp_v, input int act_v);
    $display("%0t: %s expected %0d actual %0d", $time, fld, exp_v, act_v);
    mismatch_cnt++;
  endtask

  // result check and prediction on acceptance, sampled at the rising edge
  always @(posedge clk_i) begin
    res_t       exp_r;
    res_t       pred_r;
    known_ans_t ka;
    int         idle_nxt;
    if (rst_ni) begin
      idle_nxt = idle_cycles + 1;
      if (done_o) begin
        idle_nxt = 0;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, res_o);
          mismatch_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          if (res_o.status !== exp_r.status) flag_field("status", exp_r.status, res_o.status);
          if (res_o.elem_echo !== exp_r.elem_echo)
            flag_field("elem_echo", exp_r.elem_echo, res_o.elem_echo);
          if (res_o.size !== exp_r.size) flag_field("size", exp_r.size, res_o.size);
          if (res_o.head_index !== exp_r.head_index)
            flag_field("head_index", exp_r.head_index, res_o.head_index);
        end
      end
      if (start_i && !busy_o) begin
        idle_nxt = 0;
        pred_r = apply_queue_op(req_i);
        ka = known_ans_q.pop_front();
        expected_q.push_back(ka.typed ? ka.res : pred_r);
      end
      idle_cycles <= idle_nxt;
    end
  end

  task automatic add_row(input func_e f, input int e, input bit typed, input status_e st,
                         input int sz, input int hd);
    row_t r;
    r.req.func = f;
    r.req.elem_index = IDX_W'(e);
    r.typed = typed;
    r.res.status = st;
    r.res.elem_echo = IDX_W'(e);
    r.res.size = CNT_W'(sz);
    r.res.head_index = IDX_W'(hd);
    dir_rows.push_back(r);
  endtask

  // hold the item on the port until it is taken
  task automatic send_item(input req_t r, input bit typed, input res_t ans);
    known_ans_t ka;
    ka.typed = typed;
    ka.res = ans;
    known_ans_q.push_back(ka);
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    if (int'(r.elem_index) < POOL_SIZE) begin
      if (r.func == FUNC_APPEND && !drv_member[r.elem_index]) begin
        drv_member[r.elem_index] = 1'b1;
        drv_len++;
      end else if (r.func == FUNC_REMOVE && drv_member[r.elem_index]) begin
        drv_member[r.elem_index] = 1'b0;
        drv_len--;
      end
    end
  endtask

  task automatic idle_after(input bit no_gap);
    int gap;
    int pick;
    pick = $urandom_range(0, 9);
    if (no_gap || pick < 6) gap = 0;
    else if (pick < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 20);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    req_t r;
    res_t none;
    bit   fill_mode;
    bit   no_gap;
    bit   want_append;
    int   burst_len;
    int   sent;
    int   idx;
    none = '0;

    // empty queue, duplicates, absent slots, head removal, then a full queue with a duplicate and removals
    add_row(FUNC_REMOVE, 5, 1, ST_EMPTY, 0, 0);
    add_row(FUNC_APPEND, 15, 1, ST_OK, 1, 15);
    add_row(FUNC_APPEND, 15, 1, ST_DUP, 1, 15);
    add_row(FUNC_REMOVE, 3, 1, ST_ABSENT, 1, 15);
    add_row(FUNC_REMOVE, 15, 1, ST_OK, 0, 0);
    add_row(FUNC_APPEND, 0, 1, ST_OK, 1, 0);
    for (int i = 1; i < POOL_SIZE; i++) add_row(FUNC_APPEND, i, 0, ST_OK, 0, 0);
    add_row(FUNC_APPEND, 9, 1, ST_DUP, POOL_SIZE, 0);
    add_row(FUNC_REMOVE, 0, 0, ST_OK, 0, 0);
    add_row(FUNC_REMOVE, 15, 0, ST_OK, 0, 0);
    add_row(FUNC_REMOVE, 8, 0, ST_OK, 0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
      idle_after(1'b0);
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      fill_mode = ($urandom_range(0, 1) == 1);
      no_gap = ($urandom_range(0, 3) == 0);
      burst_len = $urandom_range(10, 50);
      for (int k = 0; k < burst_len && sent < RAND_ITEMS; k++) begin
        if ($urandom_range(0, 9) < 2) begin
          r.func = func_e'($urandom_range(0, 1));
          r.elem_index = IDX_W'($urandom_range(0, POOL_SIZE - 1));
        end else begin
          want_append = fill_mode ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2);
          if (drv_len == 0) want_append = 1'b1;
          if (drv_len == POOL_SIZE) want_append = 1'b0;
          // scan from a random slot for one in the wanted membership state
          idx = $urandom_range(0, POOL_SIZE - 1);
          while (drv_member[idx] == want_append) idx = (idx + 1) % POOL_SIZE;
          r.func = want_append ? FUNC_APPEND : FUNC_REMOVE;
          r.elem_index = IDX_W'(idx);
        end
        send_item(r, 1'b0, none);
        sent++;
        if (sent == RAND_ITEMS / 2) begin
          start_i <= 1'b0;
          @(posedge clk_i);
          while (expected_q.size() != 0) @(posedge clk_i);
        end else begin
          idle_after(no_gap);
        end
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no item or result for %0d cycles", $time, IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
